/* hdl/jes3_pkg.sv */
// ----------------------------------------------------------------------------
// jes3_pkg
// Shared types and constants for the 3x3 Jacobi eigen solver core.
// ----------------------------------------------------------------------------
package jes3_pkg;

  // Q1.30 one
  localparam logic signed [31:0] ONE_Q30 = 32'sh4000_0000;
  // Q1.30 rounding half
  localparam logic [31:0] HALF_Q30 = 32'h2000_0000;

  // Register indexes on the configuration port
  localparam logic REG_EPS  = 1'b0;
  localparam logic REG_MAXR = 1'b1;

  // Last step of the rotation update sequence
  localparam logic [4:0] LAST_STEP = 5'd24;
  // First step of the eigenvector row updates
  localparam logic [4:0] VEC_STEP  = 5'd13;

  // Multiplier operand A source
  typedef enum logic [3:0] {
    OA_CT, OA_ST, OA_AIO, OA_AJO, OA_AII, OA_AJJ, OA_AIJ, OA_VI, OA_VJ
  } a_sel_t;

  // Multiplier operand B source
  typedef enum logic [2:0] {
    OB_CT, OB_ST, OB_C2, OB_S2, OB_CS
  } b_sel_t;

  // Accumulator action on the rounded product
  typedef enum logic [2:0] {
    ACC_LOAD, ACC_ADD, ACC_SUB, ACC_ADD2, ACC_SUB2
  } acc_op_t;

  // Where the accumulated value goes
  typedef enum logic [3:0] {
    DST_NONE, DST_C2, DST_S2, DST_CS, DST_BIO, DST_BJO, DST_BII, DST_BJJ,
    DST_VI, DST_VJ
  } dst_t;

  // Decoded control for one step of the rotation update
  typedef struct packed {
    a_sel_t  a_sel;
    b_sel_t  b_sel;
    acc_op_t op;
    dst_t    dst;
  } step_ctl_t;

endpackage

/* hdl/jacobi_eigen_solver_3x3_core.sv */
// ----------------------------------------------------------------------------
// jacobi_eigen_solver_3x3_core
// Classical Jacobi eigen solver for one symmetric 3x3 Q16.16 matrix.
// ----------------------------------------------------------------------------
// One matrix item is taken while the core is idle; it then runs Jacobi
// rotations on a single shared multiplier, a one-bit-per-cycle square root
// and a one-bit-per-cycle divider, and finally hands out three result items
// (eigenvalue, Q1.30 eigenvector column, rotation count, converged, last).
// Each rotation runs pivot search and prescale, two squares, two 32-step
// square roots, three 31-step divisions and a 25-multiply update, and then
// the convergence test. A run ends at the convergence test or, on a
// diagonal matrix, at the pivot search; the three results then leave at
// one per cycle when not stalled. in_stall stays high from acceptance
// until the last result is taken.
module jacobi_eigen_solver_3x3_core #(
  parameter int VALUE_WIDTH = 32
) (
  input  logic               clk,
  input  logic               rst,
  // config port
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [2:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready,
  // input channel
  input  logic               in_valid,
  output logic               in_stall,
  input  logic signed [31:0] m00,
  input  logic signed [31:0] m01,
  input  logic signed [31:0] m02,
  input  logic signed [31:0] m11,
  input  logic signed [31:0] m12,
  input  logic signed [31:0] m22,
  // output channel
  output logic               out_valid,
  input  logic               out_stall,
  output logic [1:0]         eig_index,
  output logic signed [31:0] eigenvalue,
  output logic signed [31:0] vec_x,
  output logic signed [31:0] vec_y,
  output logic signed [31:0] vec_z,
  output logic [8:0]         rotation_count,
  output logic               converged,
  output logic               last
);
  import jes3_pkg::*;

  localparam int VW   = VALUE_WIDTH;
  localparam int AW   = (VW > 32) ? VW : 32;       // multiplier operand A
  localparam int PW   = AW + 32;                   // full product
  localparam int RW   = PW - 30;                   // rounded product
  localparam int ACCW = AW + 5;                    // accumulator
  localparam int NW   = (VW + 1 > 31) ? VW + 1 : 31; // prescale magnitude

  localparam logic signed [ACCW-1:0] VMAX = {{(ACCW-VW+1){1'b0}}, {(VW-1){1'b1}}};
  localparam logic signed [ACCW-1:0] VMIN = ~VMAX;
  localparam logic signed [ACCW-1:0] SMAX = {{(ACCW-31){1'b0}}, {31{1'b1}}};
  localparam logic signed [ACCW-1:0] SMIN = ~SMAX;

  typedef enum logic [3:0] {
    S_IDLE, S_PIVOT, S_NORM, S_SQA, S_SQB, S_SQC, S_SQRT, S_DIV,
    S_MISS, S_MACC, S_CHECK, S_EMIT
  } state_t;

  typedef enum logic [2:0] {PH_H, PH_R, PH_S, PH_C, PH_T} phase_t;

  // saturate to the matrix word width
  function automatic logic signed [VW-1:0] sat_vw(input logic signed [ACCW-1:0] x);
    if (x > VMAX) return VMAX[VW-1:0];
    if (x < VMIN) return VMIN[VW-1:0];
    return x[VW-1:0];
  endfunction

  // saturate to 32 bits
  function automatic logic signed [31:0] sat_32(input logic signed [ACCW-1:0] x);
    if (x > SMAX) return SMAX[31:0];
    if (x < SMIN) return SMIN[31:0];
    return x[31:0];
  endfunction

  function automatic logic [VW-1:0] mag_vw(input logic signed [VW-1:0] x);
    return x[VW-1] ? VW'(-x) : VW'(x);
  endfunction

  // --------------------------------------------------------------------------
  // registers
  state_t state;
  phase_t phase;

  logic [15:0] eps_threshold;
  logic [7:0]  max_rotations;

  logic signed [VW-1:0] w [6];
  logic signed [31:0]   v [9];
  logic [8:0]           cnt;
  logic                 conv;
  logic [1:0]           k;

  logic [2:0] ii_idx, jj_idx, ij_idx, io_idx, jo_idx;
  logic [1:0] ci, cj;
  logic [NW-1:0] ad, ab;
  logic neg_d, neg_b;
  logic [63:0] sumsq;
  logic [31:0] h;
  logic [30:0] rq, sq;
  logic signed [31:0] ct, st, c2, s2, cs;
  logic signed [VW-1:0] nio, njo, nii;
  logic signed [31:0]   nvi;
  logic signed [ACCW-1:0] acc;
  logic [4:0] step;

  logic signed [PW-1:0] prod;

  // sqrt unit
  logic [63:0] sq_n, sq_r;
  logic [4:0]  sq_idx;
  // divider unit
  logic [32:0] dv_rem;
  logic [63:0] dv_num;
  logic [31:0] dv_den;
  logic [30:0] dv_q;
  logic [4:0]  dv_cnt;

  // --------------------------------------------------------------------------
  // config port
  logic cfg_wr;
  assign pready = 1'b1;
  assign cfg_wr = psel & penable & pwrite & pready & (paddr[1:0] == 2'b00);
  always_comb begin
    unique case (paddr[2])
      REG_EPS:  prdata = {16'd0, eps_threshold};
      REG_MAXR: prdata = {24'd0, max_rotations};
      default:  prdata = '0;
    endcase
  end

  // --------------------------------------------------------------------------
  // pivot search over the three off-diagonal entries
  logic [VW-1:0] mg1, mg2, mg4, piv_x;
  logic [1:0] piv;
  logic [2:0] p_ii, p_jj, p_ij, p_io, p_jo;
  logic [1:0] p_ci, p_cj;
  logic signed [VW:0] p_d, p_b;
  logic signed [NW-1:0] p_dx, p_bx;

  always_comb begin
    mg1 = mag_vw(w[1]);
    mg2 = mag_vw(w[2]);
    mg4 = mag_vw(w[4]);
    piv = 2'd0;
    piv_x = mg1;
    if (mg2 > piv_x) begin
      piv = 2'd1;
      piv_x = mg2;
    end
    if (mg4 > piv_x) begin
      piv = 2'd2;
      piv_x = mg4;
    end
    unique case (piv)
      2'd0: begin
        p_ii = 3'd0; p_jj = 3'd3; p_ij = 3'd1; p_io = 3'd2; p_jo = 3'd4;
        p_ci = 2'd0; p_cj = 2'd1;
      end
      2'd1: begin
        p_ii = 3'd0; p_jj = 3'd5; p_ij = 3'd2; p_io = 3'd1; p_jo = 3'd4;
        p_ci = 2'd0; p_cj = 2'd2;
      end
      default: begin
        p_ii = 3'd3; p_jj = 3'd5; p_ij = 3'd4; p_io = 3'd1; p_jo = 3'd2;
        p_ci = 2'd1; p_cj = 2'd2;
      end
    endcase
    p_d  = (VW+1)'(w[p_ii]) - (VW+1)'(w[p_jj]);
    p_b  = {w[p_ij], 1'b0};
    p_dx = NW'(p_d);
    p_bx = NW'(p_b);
  end

  // --------------------------------------------------------------------------
  // step decode for the rotation update
  step_ctl_t sc;
  logic [1:0] vrow;
  logic [3:0] vbase, vi_idx, vj_idx;
  logic [4:0] vstep;

  always_comb begin
    vstep = step - VEC_STEP;
    vrow  = vstep[3:2];
    unique case (vrow)
      2'd0:    vbase = 4'd0;
      2'd1:    vbase = 4'd3;
      default: vbase = 4'd6;
    endcase
    vi_idx = vbase + 4'(ci);
    vj_idx = vbase + 4'(cj);
    sc = '{a_sel: OA_CT, b_sel: OB_CT, op: ACC_LOAD, dst: DST_NONE};
    unique case (step)
      5'd0:  sc = '{a_sel: OA_CT,  b_sel: OB_CT, op: ACC_LOAD, dst: DST_C2};
      5'd1:  sc = '{a_sel: OA_ST,  b_sel: OB_ST, op: ACC_LOAD, dst: DST_S2};
      5'd2:  sc = '{a_sel: OA_CT,  b_sel: OB_ST, op: ACC_LOAD, dst: DST_CS};
      5'd3:  sc = '{a_sel: OA_AIO, b_sel: OB_CT, op: ACC_LOAD, dst: DST_NONE};
      5'd4:  sc = '{a_sel: OA_AJO, b_sel: OB_ST, op: ACC_ADD,  dst: DST_BIO};
      5'd5:  sc = '{a_sel: OA_AJO, b_sel: OB_CT, op: ACC_LOAD, dst: DST_NONE};
      5'd6:  sc = '{a_sel: OA_AIO, b_sel: OB_ST, op: ACC_SUB,  dst: DST_BJO};
      5'd7:  sc = '{a_sel: OA_AII, b_sel: OB_C2, op: ACC_LOAD, dst: DST_NONE};
      5'd8:  sc = '{a_sel: OA_AIJ, b_sel: OB_CS, op: ACC_ADD2, dst: DST_NONE};
      5'd9:  sc = '{a_sel: OA_AJJ, b_sel: OB_S2, op: ACC_ADD,  dst: DST_BII};
      5'd10: sc = '{a_sel: OA_AII, b_sel: OB_S2, op: ACC_LOAD, dst: DST_NONE};
      5'd11: sc = '{a_sel: OA_AIJ, b_sel: OB_CS, op: ACC_SUB2, dst: DST_NONE};
      5'd12: sc = '{a_sel: OA_AJJ, b_sel: OB_C2, op: ACC_ADD,  dst: DST_BJJ};
      default: begin
        unique case (vstep[1:0])
          2'd0: sc = '{a_sel: OA_VI, b_sel: OB_CT, op: ACC_LOAD, dst: DST_NONE};
          2'd1: sc = '{a_sel: OA_VJ, b_sel: OB_ST, op: ACC_ADD,  dst: DST_VI};
          2'd2: sc = '{a_sel: OA_VJ, b_sel: OB_CT, op: ACC_LOAD, dst: DST_NONE};
          default: sc = '{a_sel: OA_VI, b_sel: OB_ST, op: ACC_SUB, dst: DST_VJ};
        endcase
      end
    endcase
  end

  // --------------------------------------------------------------------------
  // shared multiplier operands
  logic signed [AW-1:0] ma;
  logic signed [31:0]   mb;

  always_comb begin
    ma = '0;
    mb = '0;
    if (state == S_SQA) begin
      ma = AW'($signed({1'b0, ad[30:0]}));
      mb = $signed({1'b0, ad[30:0]});
    end else if (state == S_SQB) begin
      ma = AW'($signed({1'b0, ab[30:0]}));
      mb = $signed({1'b0, ab[30:0]});
    end else begin
      unique case (sc.a_sel)
        OA_CT:   ma = AW'(ct);
        OA_ST:   ma = AW'(st);
        OA_AIO:  ma = AW'(w[io_idx]);
        OA_AJO:  ma = AW'(w[jo_idx]);
        OA_AII:  ma = AW'(w[ii_idx]);
        OA_AJJ:  ma = AW'(w[jj_idx]);
        OA_AIJ:  ma = AW'(w[ij_idx]);
        OA_VI:   ma = AW'(v[vi_idx]);
        default: ma = AW'(v[vj_idx]);
      endcase
      unique case (sc.b_sel)
        OB_CT:   mb = ct;
        OB_ST:   mb = st;
        OB_C2:   mb = c2;
        OB_S2:   mb = s2;
        default: mb = cs;
      endcase
    end
  end

  // rounding of the registered product and accumulation
  logic [PW-1:0]          prod_rnd;
  logic signed [RW-1:0]   rnd;
  logic signed [ACCW-1:0] rnd_x, acc_sum;

  always_comb begin
    prod_rnd = prod + PW'(HALF_Q30);
    rnd      = $signed(prod_rnd[PW-1:30]);
    rnd_x    = ACCW'(rnd);
    unique case (sc.op)
      ACC_LOAD: acc_sum = rnd_x;
      ACC_ADD:  acc_sum = acc + rnd_x;
      ACC_SUB:  acc_sum = acc - rnd_x;
      ACC_ADD2: acc_sum = acc + (rnd_x <<< 1);
      default:  acc_sum = acc - (rnd_x <<< 1);
    endcase
  end

  // --------------------------------------------------------------------------
  // square root step
  logic [63:0] sq_bit, sq_t, sq_n_next, sq_r_next;
  always_comb begin
    sq_bit = 64'd1 << {sq_idx, 1'b0};
    sq_t   = sq_r + sq_bit;
    if (sq_n >= sq_t) begin
      sq_n_next = sq_n - sq_t;
      sq_r_next = (sq_r >> 1) + sq_bit;
    end else begin
      sq_n_next = sq_n;
      sq_r_next = sq_r >> 1;
    end
  end

  // division step
  logic [32:0] dv_sh, dv_rem_next;
  logic [30:0] dv_q_next;
  always_comb begin
    dv_sh = {dv_rem[31:0], dv_num[dv_cnt]};
    if (dv_sh >= {1'b0, dv_den}) begin
      dv_rem_next = dv_sh - {1'b0, dv_den};
      dv_q_next   = {dv_q[29:0], 1'b1};
    end else begin
      dv_rem_next = dv_sh;
      dv_q_next   = {dv_q[29:0], 1'b0};
    end
  end

  // convergence test values
  logic [VW+2:0] off_sum;
  logic [8:0]    cnt_next;
  logic [31:0]   u_val;
  always_comb begin
    off_sum  = ((VW+3)'(mag_vw(w[1])) + (VW+3)'(mag_vw(w[2])) + (VW+3)'(mag_vw(w[4]))) << 1;
    cnt_next = cnt + 9'd1;
    u_val    = (32'(rq) + 32'(ONE_Q30)) >> 1;
  end

  // --------------------------------------------------------------------------
  // multiplier register
  always_ff @(posedge clk) begin
    prod <= PW'(ma) * PW'(mb);
  end

  // --------------------------------------------------------------------------
  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      phase         <= PH_H;
      eps_threshold <= 16'd1;
      max_rotations <= 8'd100;
      cnt           <= '0;
      conv          <= 1'b0;
      k             <= '0;
      step          <= '0;
    end else begin
      if (cfg_wr) begin
        unique case (paddr[2])
          REG_EPS:  eps_threshold <= pwdata[15:0];
          REG_MAXR: max_rotations <= pwdata[7:0];
          default: ;
        endcase
      end

      unique case (state)
        // load matrix and identity vectors
        S_IDLE: begin
          if (in_valid) begin
            w[0] <= sat_vw(ACCW'(m00));
            w[1] <= sat_vw(ACCW'(m01));
            w[2] <= sat_vw(ACCW'(m02));
            w[3] <= sat_vw(ACCW'(m11));
            w[4] <= sat_vw(ACCW'(m12));
            w[5] <= sat_vw(ACCW'(m22));
            for (int q = 0; q < 9; q++) begin
              v[q] <= (q % 4 == 0) ? ONE_Q30 : 32'sd0;
            end
            cnt   <= '0;
            conv  <= 1'b0;
            k     <= '0;
            state <= S_PIVOT;
          end
        end

        // pick pivot, or stop on a diagonal matrix
        S_PIVOT: begin
          if (piv_x == '0) begin
            conv  <= 1'b1;
            state <= S_EMIT;
          end else begin
            ii_idx <= p_ii; jj_idx <= p_jj; ij_idx <= p_ij;
            io_idx <= p_io; jo_idx <= p_jo;
            ci <= p_ci; cj <= p_cj;
            neg_d <= p_d[VW];
            neg_b <= p_b[VW];
            ad    <= p_dx[NW-1] ? NW'(-p_dx) : NW'(p_dx);
            ab    <= p_bx[NW-1] ? NW'(-p_bx) : NW'(p_bx);
            state <= S_NORM;
          end
        end

        // scale both down below 2^31
        S_NORM: begin
          if ((ad >> 31) != '0 || (ab >> 31) != '0) begin
            ad <= ad >> 1;
            ab <= ab >> 1;
          end else begin
            state <= S_SQA;
          end
        end

        S_SQA: state <= S_SQB;

        S_SQB: begin
          sumsq <= prod[63:0];
          state <= S_SQC;
        end

        // start sqrt of d^2 + b^2
        S_SQC: begin
          sq_n   <= sumsq + prod[63:0];
          sq_r   <= '0;
          sq_idx <= 5'd31;
          phase  <= PH_H;
          state  <= S_SQRT;
        end

        S_SQRT: begin
          sq_n   <= sq_n_next;
          sq_r   <= sq_r_next;
          sq_idx <= sq_idx - 5'd1;
          if (sq_idx == '0) begin
            if (phase == PH_H) begin
              h <= sq_r_next[31:0];
              if (sq_r_next == '0) begin
                conv  <= 1'b1;
                state <= S_EMIT;
              end else begin
                dv_num <= 64'(ad[30:0]) << 30;
                dv_den <= sq_r_next[31:0];
                dv_rem <= {2'b00, ad[30:0]} >> 1;
                dv_q   <= '0;
                dv_cnt <= 5'd30;
                phase  <= PH_R;
                state  <= S_DIV;
              end
            end else begin
              ct     <= $signed(sq_r_next[31:0]);
              dv_num <= 64'(sq) << 30;
              dv_den <= {sq_r_next[30:0], 1'b0};
              dv_rem <= 33'(sq) >> 1;
              dv_q   <= '0;
              dv_cnt <= 5'd30;
              phase  <= PH_T;
              state  <= S_DIV;
            end
          end
        end

        S_DIV: begin
          dv_rem <= dv_rem_next;
          dv_q   <= dv_q_next;
          dv_cnt <= dv_cnt - 5'd1;
          if (dv_cnt == '0) begin
            unique case (phase)
              PH_R: begin
                rq     <= dv_q_next;
                dv_num <= 64'(ab[30:0]) << 30;
                dv_den <= h;
                dv_rem <= {2'b00, ab[30:0]} >> 1;
                dv_q   <= '0;
                dv_cnt <= 5'd30;
                phase  <= PH_S;
              end
              PH_S: begin
                sq     <= dv_q_next;
                sq_n   <= 64'(u_val) << 30;
                sq_r   <= '0;
                sq_idx <= 5'd31;
                phase  <= PH_C;
                state  <= S_SQRT;
              end
              default: begin
                st    <= (neg_d != neg_b) ? -$signed({1'b0, dv_q_next}) :
                                             $signed({1'b0, dv_q_next});
                step  <= '0;
                state <= S_MISS;
              end
            endcase
          end
        end

        S_MISS: state <= S_MACC;

        // accumulate and write back
        S_MACC: begin
          acc <= acc_sum;
          unique case (sc.dst)
            DST_C2:  c2  <= $signed(acc_sum[31:0]);
            DST_S2:  s2  <= $signed(acc_sum[31:0]);
            DST_CS:  cs  <= $signed(acc_sum[31:0]);
            DST_BIO: nio <= sat_vw(acc_sum);
            DST_BJO: njo <= sat_vw(acc_sum);
            DST_BII: nii <= sat_vw(acc_sum);
            DST_BJJ: begin
              w[io_idx] <= nio;
              w[jo_idx] <= njo;
              w[ii_idx] <= nii;
              w[jj_idx] <= sat_vw(acc_sum);
              w[ij_idx] <= '0;
            end
            DST_VI:  nvi <= sat_32(acc_sum);
            DST_VJ: begin
              v[vi_idx] <= nvi;
              v[vj_idx] <= sat_32(acc_sum);
            end
            default: ;
          endcase
          if (step == LAST_STEP) begin
            state <= S_CHECK;
          end else begin
            step  <= step + 5'd1;
            state <= S_MISS;
          end
        end

        S_CHECK: begin
          cnt <= cnt_next;
          if (off_sum < (VW+3)'(eps_threshold)) begin
            conv  <= 1'b1;
            state <= S_EMIT;
          end else if (cnt_next > {1'b0, max_rotations}) begin
            state <= S_EMIT;
          end else begin
            state <= S_PIVOT;
          end
        end

        S_EMIT: begin
          if (!out_stall) begin
            k <= k + 2'd1;
            if (k == 2'd2) begin
              state <= S_IDLE;
            end
          end
        end

        default: state <= S_IDLE;
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // outputs
  logic [2:0] diag_idx;
  always_comb begin
    unique case (k)
      2'd0:    diag_idx = 3'd0;
      2'd1:    diag_idx = 3'd3;
      default: diag_idx = 3'd5;
    endcase
  end

  assign in_stall       = (state != S_IDLE);
  assign out_valid      = (state == S_EMIT);
  assign eig_index      = k;
  assign eigenvalue     = sat_32(ACCW'(w[diag_idx]));
  assign vec_x          = v[4'(k)];
  assign vec_y          = v[4'(k) + 4'd3];
  assign vec_z          = v[4'(k) + 4'd6];
  assign rotation_count = cnt;
  assign converged      = conv;
  assign last           = (k == 2'd2);

endmodule
